// File: rtl/core/bps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

    localparam int FRAC_BITS = 24;
    localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] EPS_Q = (ONE_Q + 64'sd500000) / 64'sd1000000;
    localparam logic signed [63:0] TENTH_Q = (ONE_Q + 64'sd5) / 64'sd10;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam int RADIUS_W = 25;
    localparam int GRAV_W = 25;
    localparam int MASS_W = 29;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 25;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 25'd838861;
    localparam logic GRAV_ON_RST = 1'b1;
    localparam logic [GRAV_W-1:0] GRAV_RST = 25'd33554;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_COLLIDE = 2'd1;
    localparam logic [1:0] CMD_PLACE = 2'd2;
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRAV_ON = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GRAV = 2'd2;

    localparam logic OP_DIV = 1'b0;
    localparam logic OP_SQRT = 1'b1;
    localparam int DIV_STEPS = 64;
    localparam int SQRT_STEPS = 32;
    localparam int DEN_W = 34;

    typedef logic signed [31:0] t_word;

    typedef struct packed {
        logic start;
        logic op;
        logic [63:0] num;
        logic [DEN_W-1:0] den;
    } t_unit_req;

    typedef struct packed {
        logic done;
        logic [63:0] result;
    } t_unit_rsp;

    function automatic t_word sat32(input logic signed [63:0] v);
        t_word r;
        if (v > 64'(S32_MAX)) r = S32_MAX;
        else if (v < 64'(S32_MIN)) r = S32_MIN;
        else r = v[31:0];
        return r;
    endfunction

    // divide by ONE, truncating toward zero
    function automatic logic signed [63:0] div_one(input logic signed [63:0] v);
        logic signed [63:0] bias;
        bias = v[63] ? (ONE_Q - 64'sd1) : 64'sd0;
        return (v + bias) >>> FRAC_BITS;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/bps_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bps_in_if;
    logic valid;
    logic ready;
    logic [1:0] cmd;
    logic signed [31:0] in_pos_x;
    logic signed [31:0] in_pos_y;
    logic signed [31:0] in_vel_x;
    logic signed [31:0] in_vel_y;
    logic [28:0] other_mass;

    modport source (output valid, cmd, in_pos_x, in_pos_y, in_vel_x, in_vel_y, other_mass,
                    input ready);
    modport sink (input valid, cmd, in_pos_x, in_pos_y, in_vel_x, in_vel_y, other_mass,
                  output ready);
endinterface

interface bps_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic impulse_added;
    logic wall_x_hit;
    logic wall_y_hit;

    modport source (output valid, pos_x, pos_y, vel_x, vel_y, impulse_added, wall_x_hit,
                    wall_y_hit, input ready);
    modport sink (input valid, pos_x, pos_y, vel_x, vel_y, impulse_added, wall_x_hit,
                  wall_y_hit, output ready);
endinterface

interface bps_cfg_if;
    logic valid;
    logic ready;
    logic [1:0] addr;
    logic [24:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bps_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module bps_mul (
    input  wire logic               i_clk,
    input  wire logic signed [32:0] i_a,
    input  wire logic signed [32:0] i_b,
    output logic signed [63:0]      o_prod
);
    logic signed [65:0] full;
    logic signed [63:0] r_prod;

    assign full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= full[63:0];
    end

    assign o_prod = r_prod;
endmodule

`default_nettype wire

// File: rtl/core/bps_divsqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module bps_divsqrt (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire bps_pkg::t_unit_req  i_req,
    output bps_pkg::t_unit_rsp       o_rsp
);
    import bps_pkg::*;

    logic r_busy;
    logic r_done;
    logic r_op;
    logic [5:0] r_cnt;
    logic [63:0] r_quo;
    logic [35:0] r_rem;
    logic [31:0] r_root;
    logic [DEN_W-1:0] r_den;

    logic [35:0] div_shift, sq_shift, sq_trial;
    logic div_ge, sq_ge;
    logic [63:0] n_quo;
    logic [35:0] n_rem;
    logic [31:0] n_root;

    always_comb begin
        div_shift = {r_rem[34:0], r_quo[63]};
        div_ge = div_shift >= {2'b00, r_den};
        sq_shift = {r_rem[33:0], r_quo[63:62]};
        sq_trial = {2'b00, r_root, 2'b01};
        sq_ge = sq_shift >= sq_trial;
        n_root = r_root;
        if (r_op == OP_DIV) begin
            n_rem = div_ge ? (div_shift - {2'b00, r_den}) : div_shift;
            n_quo = {r_quo[62:0], div_ge};
        end else begin
            n_rem = sq_ge ? (sq_shift - sq_trial) : sq_shift;
            n_quo = {r_quo[61:0], 2'b00};
            n_root = {r_root[30:0], sq_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == 6'd0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op <= i_req.op;
                r_quo <= i_req.num;
                r_rem <= '0;
                r_root <= '0;
                r_den <= i_req.den;
                r_cnt <= (i_req.op == OP_DIV) ? 6'(DIV_STEPS - 1) : 6'(SQRT_STEPS - 1);
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_root <= n_root;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.result = (r_op == OP_DIV) ? r_quo : {32'b0, r_root};
endmodule

`default_nettype wire

// File: rtl/core/ball_physics_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One 2D ball in signed Q8.24, advanced by tick, collide and place requests, each
// answered by one result with the ball state after it. A request is taken only when
// the block is idle; the finished result sits in an output register, so the next
// request can be taken while it waits. Place and the unused command go straight to
// the result. A tick adds the kicks to the velocity, moves the ball and fixes wall
// hits, after a gravity division when gravity is on. A collide is set by the shared
// bit-serial divide/root unit: a distance root and up to three divisions, with the
// products going through one registered 33x33 multiplier. Configuration writes are
// always ready and are meant for idle periods.
module ball_physics_step (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bps_in_if.sink     i_req,
    bps_out_if.source  o_rsp,
    bps_cfg_if.sink    i_cfg
);
    import bps_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SQ_X   = 5'd1;
    localparam logic [4:0] S_SQ_Y   = 5'd2;
    localparam logic [4:0] S_SQ_SUM = 5'd3;
    localparam logic [4:0] S_SQRT   = 5'd4;
    localparam logic [4:0] S_DIV_NX = 5'd5;
    localparam logic [4:0] S_W_NX   = 5'd6;
    localparam logic [4:0] S_DIV_NY = 5'd7;
    localparam logic [4:0] S_W_NY   = 5'd8;
    localparam logic [4:0] S_VN_A   = 5'd9;
    localparam logic [4:0] S_VN_B   = 5'd10;
    localparam logic [4:0] S_VN_C   = 5'd11;
    localparam logic [4:0] S_W_F    = 5'd12;
    localparam logic [4:0] S_DV     = 5'd13;
    localparam logic [4:0] S_DV_C   = 5'd14;
    localparam logic [4:0] S_KX_M   = 5'd15;
    localparam logic [4:0] S_KY_M   = 5'd16;
    localparam logic [4:0] S_KY     = 5'd17;
    localparam logic [4:0] S_GRAV   = 5'd18;
    localparam logic [4:0] S_W_G    = 5'd19;
    localparam logic [4:0] S_T1     = 5'd20;
    localparam logic [4:0] S_T2     = 5'd21;
    localparam logic [4:0] S_T3     = 5'd22;
    localparam logic [4:0] S_DONE   = 5'd23;

    typedef struct packed {
        t_word p;
        t_word v;
        logic hit;
    } t_wall;

    function automatic t_wall wall_fix(input t_word p, input t_word v,
                                       input logic [RADIUS_W-1:0] r);
        t_wall w;
        logic signed [63:0] lo, hi, rr;
        rr = $signed(64'(r));
        lo = -ONE_Q + rr;
        hi = ONE_Q - rr;
        w.p = p;
        w.v = v;
        w.hit = 1'b0;
        if (64'(p) < lo) begin
            w.p = lo[31:0];
            w.hit = 1'b1;
            if (v < 0) w.v = (v == S32_MIN) ? S32_MAX : -v;
        end else if (64'(p) > hi) begin
            w.p = hi[31:0];
            w.hit = 1'b1;
            if (v > 0) w.v = -v;
        end
        return w;
    endfunction

    logic [4:0] r_state;
    logic [RADIUS_W-1:0] r_radius;
    logic r_grav_on;
    logic [GRAV_W-1:0] r_grav;

    t_word r_pos_x, r_pos_y, r_vel_x, r_vel_y, r_kick_x, r_kick_y;
    t_word r_dx, r_dy, r_rx, r_ry, r_vn, r_dv;
    logic [31:0] r_dist;
    logic [MASS_W-1:0] r_m2;
    logic [63:0] r_acc;
    logic signed [32:0] r_nx, r_ny, r_f;
    logic r_imp, r_hx, r_hy;

    logic r_out_valid;
    t_word r_out_px, r_out_py, r_out_vx, r_out_vy;
    logic r_out_imp, r_out_hx, r_out_hy;

    logic signed [32:0] mul_a, mul_b;
    logic signed [63:0] prod;
    t_unit_req u_req;
    t_unit_rsp u_rsp;

    logic [32:0] ax, ay;
    logic [29:0] m1;
    logic [30:0] msum;
    logic signed [63:0] ysum, dabs, dgrav;
    logic signed [63:0] vn_sum;
    t_word vn_now;
    logic kick_go;
    logic signed [32:0] q33;
    t_wall wx, wy;
    logic accept;

    bps_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    bps_divsqrt u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req),
        .o_rsp   (u_rsp)
    );

    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        ax = r_dx[31] ? (33'd0 - {r_dx[31], r_dx}) : {1'b0, r_dx};
        ay = r_dy[31] ? (33'd0 - {r_dy[31], r_dy}) : {1'b0, r_dy};
        m1 = 30'({r_radius, 4'b0000}) + 30'({r_radius, 2'b00});
        msum = 31'(m1) + 31'(r_m2);
        ysum = 64'(r_pos_y) + ONE_Q;
        dabs = ysum[63] ? -ysum : ysum;
        dgrav = (dabs < TENTH_Q) ? TENTH_Q : dabs;
        vn_sum = $signed(r_acc) + prod;
        vn_now = sat32(div_one(vn_sum));
        kick_go = vn_now[31] && (msum != 31'd0);
        q33 = u_rsp.result[32:0];
        wx = wall_fix(r_pos_x, r_vel_x, r_radius);
        wy = wall_fix(r_pos_y, r_vel_y, r_radius);
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQ_X: begin
                mul_a = $signed(ax);
                mul_b = $signed(ax);
            end
            S_SQ_Y: begin
                mul_a = $signed(ay);
                mul_b = $signed(ay);
            end
            S_VN_A: begin
                mul_a = 33'(r_rx);
                mul_b = r_nx;
            end
            S_VN_B: begin
                mul_a = 33'(r_ry);
                mul_b = r_ny;
            end
            S_DV: begin
                mul_a = 33'(r_vn);
                mul_b = r_f;
            end
            S_KX_M: begin
                mul_a = 33'(r_dv);
                mul_b = r_nx;
            end
            S_KY_M: begin
                mul_a = 33'(r_dv);
                mul_b = r_ny;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // launch requests for the divide/root unit
    always_comb begin
        u_req.start = 1'b0;
        u_req.op = OP_DIV;
        u_req.num = '0;
        u_req.den = '0;
        unique case (r_state)
            S_SQ_SUM: begin
                u_req.start = 1'b1;
                u_req.op = OP_SQRT;
                u_req.num = r_acc + prod;
            end
            S_DIV_NX: begin
                u_req.start = 1'b1;
                u_req.num = 64'(ax) << FRAC_BITS;
                u_req.den = DEN_W'(r_dist);
            end
            S_DIV_NY: begin
                u_req.start = 1'b1;
                u_req.num = 64'(ay) << FRAC_BITS;
                u_req.den = DEN_W'(r_dist);
            end
            S_VN_C: begin
                u_req.start = kick_go;
                u_req.num = 64'(r_m2) << (FRAC_BITS + 1);
                u_req.den = DEN_W'(msum);
            end
            S_GRAV: begin
                u_req.start = 1'b1;
                u_req.num = 64'(r_grav) << FRAC_BITS;
                u_req.den = dgrav[DEN_W-1:0];
            end
            default: begin
                u_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_radius <= RADIUS_RST;
            r_grav_on <= GRAV_ON_RST;
            r_grav <= GRAV_RST;
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_vel_x <= '0;
            r_vel_y <= '0;
            r_kick_x <= '0;
            r_kick_y <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.addr)
                    REG_RADIUS: r_radius <= i_cfg.data;
                    REG_GRAV_ON: r_grav_on <= i_cfg.data[0];
                    REG_GRAV: r_grav <= i_cfg.data;
                    default: ;
                endcase
            end

            if (r_out_valid && o_rsp.ready && (r_state != S_DONE)) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_imp <= 1'b0;
                        r_hx <= 1'b0;
                        r_hy <= 1'b0;
                        r_dx <= sat32(64'(i_req.in_pos_x) - 64'(r_pos_x));
                        r_dy <= sat32(64'(i_req.in_pos_y) - 64'(r_pos_y));
                        r_rx <= sat32(64'(i_req.in_vel_x) - 64'(r_vel_x));
                        r_ry <= sat32(64'(i_req.in_vel_y) - 64'(r_vel_y));
                        r_m2 <= i_req.other_mass;
                        unique case (i_req.cmd)
                            CMD_TICK: r_state <= r_grav_on ? S_GRAV : S_T1;
                            CMD_COLLIDE: r_state <= S_SQ_X;
                            CMD_PLACE: begin
                                r_pos_x <= i_req.in_pos_x;
                                r_pos_y <= i_req.in_pos_y;
                                r_vel_x <= i_req.in_vel_x;
                                r_vel_y <= i_req.in_vel_y;
                                r_kick_x <= '0;
                                r_kick_y <= '0;
                                r_state <= S_DONE;
                            end
                            CMD_NOP: r_state <= S_DONE;
                        endcase
                    end
                end
                S_SQ_X: r_state <= S_SQ_Y;
                S_SQ_Y: begin
                    r_acc <= prod;
                    r_state <= S_SQ_SUM;
                end
                S_SQ_SUM: r_state <= S_SQRT;
                S_SQRT: begin
                    if (u_rsp.done) begin
                        r_dist <= u_rsp.result[31:0];
                        // too close to give a direction: drop the request
                        if ($signed(u_rsp.result) <= EPS_Q) r_state <= S_DONE;
                        else r_state <= S_DIV_NX;
                    end
                end
                S_DIV_NX: r_state <= S_W_NX;
                S_W_NX: begin
                    if (u_rsp.done) begin
                        r_nx <= r_dx[31] ? -q33 : q33;
                        r_state <= S_DIV_NY;
                    end
                end
                S_DIV_NY: r_state <= S_W_NY;
                S_W_NY: begin
                    if (u_rsp.done) begin
                        r_ny <= r_dy[31] ? -q33 : q33;
                        r_state <= S_VN_A;
                    end
                end
                S_VN_A: r_state <= S_VN_B;
                S_VN_B: begin
                    r_acc <= prod;
                    r_state <= S_VN_C;
                end
                S_VN_C: begin
                    r_vn <= vn_now;
                    r_state <= kick_go ? S_W_F : S_DONE;
                end
                S_W_F: begin
                    if (u_rsp.done) begin
                        r_f <= q33;
                        r_state <= S_DV;
                    end
                end
                S_DV: r_state <= S_DV_C;
                S_DV_C: begin
                    r_dv <= sat32(div_one(prod));
                    r_state <= S_KX_M;
                end
                S_KX_M: r_state <= S_KY_M;
                S_KY_M: begin
                    r_kick_x <= sat32(64'(r_kick_x) + div_one(prod));
                    r_state <= S_KY;
                end
                S_KY: begin
                    r_kick_y <= sat32(64'(r_kick_y) + div_one(prod));
                    r_imp <= 1'b1;
                    r_state <= S_DONE;
                end
                S_GRAV: r_state <= S_W_G;
                S_W_G: begin
                    if (u_rsp.done) begin
                        r_vel_y <= sat32(64'(r_vel_y) - $signed(u_rsp.result));
                        r_state <= S_T1;
                    end
                end
                S_T1: begin
                    r_vel_x <= sat32(64'(r_vel_x) + 64'(r_kick_x));
                    r_vel_y <= sat32(64'(r_vel_y) + 64'(r_kick_y));
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_pos_x <= sat32(64'(r_pos_x) + 64'(r_vel_x));
                    r_pos_y <= sat32(64'(r_pos_y) + 64'(r_vel_y));
                    r_state <= S_T3;
                end
                S_T3: begin
                    r_pos_x <= wx.p;
                    r_vel_x <= wx.v;
                    r_hx <= wx.hit;
                    r_pos_y <= wy.p;
                    r_vel_y <= wy.v;
                    r_hy <= wy.hit;
                    r_kick_x <= '0;
                    r_kick_y <= '0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_px <= r_pos_x;
                        r_out_py <= r_pos_y;
                        r_out_vx <= r_vel_x;
                        r_out_vy <= r_vel_y;
                        r_out_imp <= r_imp;
                        r_out_hx <= r_hx;
                        r_out_hy <= r_hy;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.pos_x = r_out_px;
    assign o_rsp.pos_y = r_out_py;
    assign o_rsp.vel_x = r_out_vx;
    assign o_rsp.vel_y = r_out_vy;
    assign o_rsp.impulse_added = r_out_imp;
    assign o_rsp.wall_x_hit = r_out_hx;
    assign o_rsp.wall_y_hit = r_out_hy;
endmodule

`default_nettype wire

// File: rtl/core/bps_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bps_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_out_pos_x,
    input wire logic [31:0] i_out_vel_y,
    input wire logic        i_out_imp,
    input wire logic        i_out_hx,
    input wire logic        i_out_hy
);
    // ready drops after every request is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready stayed high after a request was taken");

    // a kick comes only from collide, a wall hit only from tick
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_imp && (i_out_hx || i_out_hy)))
        else $error("impulse and wall flags in one result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_pos_x) && $stable(i_out_vel_y)))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind ball_physics_step bps_checker u_bps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_pos_x (o_rsp.pos_x),
    .i_out_vel_y (o_rsp.vel_y),
    .i_out_imp   (o_rsp.impulse_added),
    .i_out_hx    (o_rsp.wall_x_hit),
    .i_out_hy    (o_rsp.wall_y_hit)
);

`default_nettype wire
